>>> rtl/core/utf8_lenient_decoder_top_assert.svh
// assertion macros for the lenient utf-8 decoder
// expects signals named clock and reset in the module that includes it
`ifndef UTF8_LENIENT_DECODER_TOP_ASSERT_SVH
`define UTF8_LENIENT_DECODER_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define U8DEC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("u8dec check failed");

// consequent checked in the cycle after the antecedent
`define U8DEC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("u8dec check failed");

`endif

>>> rtl/core/u8dec_pkg.sv
// shared types and constants for the lenient utf-8 decoder
// no dependencies
`default_nettype none

package u8dec_pkg;

   localparam int unsigned CpWidth    = 21;
   localparam int unsigned MaxResults = 4;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned HeldDepth  = 3;

   // sequence length codes
   localparam logic [2:0] LenIdle  = 3'd0;
   localparam logic [2:0] LenOne   = 3'd1;
   localparam logic [2:0] LenTwo   = 3'd2;
   localparam logic [2:0] LenThree = 3'd3;
   localparam logic [2:0] LenFour  = 3'd4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               run_last;
   } rsp_payload_type;

   // all results caused by one input byte
   typedef struct packed {
      logic [MaxResults-1:0][CpWidth-1:0] cp;
      logic [CountWidth-1:0]              count;
   } group_type;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      if ((b & 8'hE0) == 8'hC0) begin
         len = LenTwo;
      end else if ((b & 8'hF0) == 8'hE0) begin
         len = LenThree;
      end else if ((b & 8'hF8) == 8'hF0) begin
         len = LenFour;
      end else begin
         len = LenOne;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/u8dec_parse.sv
// sequence tracker of the lenient utf-8 decoder: holds the open sequence
// and builds the result group for each byte; uses u8dec_pkg
`default_nettype none

module u8dec_parse (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire u8dec_pkg::req_payload_type req,
   output u8dec_pkg::group_type           group
);

   logic [7:0] held_ff [u8dec_pkg::HeldDepth];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic [2:0] seq_ff;
   logic [2:0] seq_in;

   logic [7:0] b;
   logic       eot;
   logic       cont;
   logic       open;
   logic       complete;
   logic [2:0] len;
   logic [2:0] flush_n;
   logic       emit_b;
   logic [u8dec_pkg::CpWidth-1:0] cp;
   logic       store_cont;
   logic       store_lead;

   always_comb begin
      b    = req.text_byte;
      eot  = req.end_of_text;
      cont = (b[7:6] == 2'b10);
      open = (seq_ff != u8dec_pkg::LenIdle);
      len  = u8dec_pkg::lead_length(b);
      complete = open && cont &&
                 ((({1'b0, count_ff} + 3'd1) >= seq_ff) || (count_ff == 2'd3));

      case (seq_ff)
         u8dec_pkg::LenTwo: begin
            cp = {10'd0, held_ff[0][4:0], b[5:0]};
         end
         u8dec_pkg::LenThree: begin
            cp = {5'd0, held_ff[0][3:0], held_ff[1][5:0], b[5:0]};
         end
         default: begin
            cp = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0], b[5:0]};
         end
      endcase

      // held bytes go out raw when the sequence breaks or the text ends early
      flush_n = (open && !complete && (!cont || eot)) ? {1'b0, count_ff} : 3'd0;
      if (complete) begin
         emit_b = 1'b0;
      end else if (open && cont) begin
         emit_b = eot;
      end else begin
         emit_b = (len == u8dec_pkg::LenOne) || eot;
      end

      for (int k = 0; k < u8dec_pkg::HeldDepth; k++) begin
         if (3'(k) < flush_n) begin
            group.cp[k] = {13'd0, held_ff[k]};
         end else begin
            group.cp[k] = {13'd0, b};
         end
      end
      group.cp[u8dec_pkg::MaxResults-1] = {13'd0, b};
      if (complete) begin
         group.cp[0] = cp;
      end
      group.count = complete ? 3'd1 : (flush_n + {2'd0, emit_b});

      store_cont = open && cont && !complete && !eot;
      store_lead = (!open || !cont) && (len != u8dec_pkg::LenOne) && !eot;
      if (store_cont) begin
         count_in = count_ff + 2'd1;
         seq_in   = seq_ff;
      end else if (store_lead) begin
         count_in = 2'd1;
         seq_in   = len;
      end else begin
         count_in = 2'd0;
         seq_in   = u8dec_pkg::LenIdle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         seq_ff   <= u8dec_pkg::LenIdle;
      end else if (accept) begin
         count_ff <= count_in;
         seq_ff   <= seq_in;
      end
   end

   // held bytes carry no reset, only entries below the count are read
   always_ff @(posedge clock) begin
      if (accept && store_lead) begin
         held_ff[0] <= b;
      end
      for (int k = 1; k < u8dec_pkg::HeldDepth; k++) begin
         if (accept && store_cont && (count_ff == 2'(k))) begin
            held_ff[k] <= b;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/utf8_lenient_decoder_top.sv
// Lenient UTF-8 decoder, one text byte in per transfer, code points out.
//
// req channel: req_payload carries text_byte and end_of_text; a transfer
// happens when req_valid is high and req_stall is low.
// rsp channel: rsp_payload carries code_point and run_last; run_last marks
// the last result caused by one input byte. Bytes that only extend an open
// sequence give no result at all.
// Latency: results of a byte appear on rsp the cycle after its transfer.
// Throughput: one byte per cycle while rsp_stall is low and each
// byte yields at most one result. A byte that yields several results
// (a broken or cut-off sequence, up to four) holds req_stall until the
// single result register bank drains them, one entry per cycle while
// rsp_stall is low. A new byte is taken in the same cycle the last
// pending result transfers. Reset (synchronous, active high) empties the
// result bank and closes any open sequence. While rsp_stall is high the
// presented result holds; req_stall is high while any result is pending.
`default_nettype none

module utf8_lenient_decoder_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire u8dec_pkg::req_payload_type req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output u8dec_pkg::rsp_payload_type      rsp_payload
);

`include "utf8_lenient_decoder_top_assert.svh"

   u8dec_pkg::group_type group;

   logic [u8dec_pkg::CpWidth-1:0]    pend_cp_ff [u8dec_pkg::MaxResults];
   logic [u8dec_pkg::CountWidth-1:0] pend_ff;
   logic [u8dec_pkg::CountWidth-1:0] pend_in;
   logic [1:0]                       head_ff;
   logic [1:0]                       head_in;
   logic                             req_accept;
   logic                             rsp_pop;

   u8dec_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_payload),
      .group  (group)
   );

   always_comb begin
      rsp_valid = (pend_ff != '0);
      rsp_pop   = rsp_valid && !rsp_stall;
      // free when empty or when the last pending result leaves this cycle
      req_stall  = !((pend_ff == '0) || ((pend_ff == 3'd1) && !rsp_stall));
      req_accept = req_valid && !req_stall;
      rsp_payload.code_point = pend_cp_ff[head_ff];
      rsp_payload.run_last   = (pend_ff == 3'd1);

      if (req_accept) begin
         pend_in = group.count;
         head_in = 2'd0;
      end else if (rsp_pop) begin
         pend_in = pend_ff - 3'd1;
         head_in = head_ff + 2'd1;
      end else begin
         pend_in = pend_ff;
         head_in = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         head_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int k = 0; k < u8dec_pkg::MaxResults; k++) begin
            pend_cp_ff[k] <= group.cp[k];
         end
      end
   end

   `U8DEC_ASSERT_NOW(a_pend_bound, 1'b1, pend_ff <= 3'd4)
   `U8DEC_ASSERT_NOW(a_no_overwrite, req_accept && (pend_ff != '0),
                     rsp_valid && !rsp_stall && rsp_payload.run_last)
   `U8DEC_ASSERT_NEXT(a_burst_continues, rsp_valid && !rsp_stall && !rsp_payload.run_last,
                      rsp_valid)

endmodule

`default_nettype wire
